[rtl/nce_pkg.sv]
// shared constants, register codes and defaults for the north compass edge filter
// no dependencies; imported by every module of the block
package nce_pkg;

    localparam int CH_W        = 8;
    localparam int SUM_W       = 10;
    localparam int ROW_WIDTH_W = 12;
    localparam int WEIGHT_W    = 8;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MSIZE      = 3;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 12'd640;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RST    = 8'sd1;

    // divide by three through a reciprocal, valid for totals below DIV3_LIMIT
    localparam int DIV3_RECIP = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_LIMIT = 768;
    localparam int DIV3_IN_W  = 10;
    localparam int DIV3_PR_W  = 20;
    localparam logic [CH_W-1:0] CLAMP_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH = 1'b0,
        CFG_WEIGHT    = 1'b1
    } t_cfg_reg;

endpackage

[rtl/north_compass_edge_filter_core.sv]
// top level of the north compass edge filter: pixel counters, line store access,
// window and response pipeline; uses nce_pkg, nce_line_mem, nce_window, nce_calc
//
// Pixels arrive in raster order on i_valid/o_stall, one beat per pixel with its
// blue, green and red channels and a start-of-frame flag that restarts the
// column and row counters. Each beat is reduced to a channel sum; a line store
// with one read and one write port per cycle holds the sums of the last MSIZE-1
// rows, addressed by column. A result beat on o_valid/i_stall carries the grey
// response and the coordinates of the window centre, and is produced only for
// pixels whose window is complete; border pixels give no beat.
// Throughput is one pixel per clock while o_stall is low, set by the single line
// store read and write per pixel. When the receiver stalls, the result holds in
// the output register while the inner stages keep filling; o_stall rises only
// once every stage is occupied. Reset clears the counters, the window and the
// pipeline and loads row_width 640 and weight 1; the line store is not cleared
// and needs no sweep. Configuration is to be written only while idle, through
// i_cfg_we/i_cfg_idx/i_cfg_data; the block itself does not enforce this.
module north_compass_edge_filter_core import nce_pkg::*; #(
    parameter int MSIZE      = DEF_MSIZE,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [CH_W-1:0]               i_blue,
    input  logic [CH_W-1:0]               i_green,
    input  logic [CH_W-1:0]               i_red,
    input  logic                          i_start_of_frame,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [CH_W-1:0]               o_edge_value,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_center_col,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_center_row
);

    localparam int HALF  = MSIZE / 2;
    localparam int LINES = MSIZE - 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int EW    = CW + 1;
    localparam int TW    = SUM_W + 2 * $clog2(MSIZE);
    localparam int LW    = LINES * SUM_W;

    logic [ROW_WIDTH_W-1:0]     r_row_width;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;

    logic                       r_v1;
    logic                       r_full1;
    logic [SUM_W-1:0]           r_sum1;
    logic [CW-1:0]              r_col1;
    logic [RW-1:0]              r_row1;

    logic                       r_v2;
    logic [CW-1:0]              r_col2;
    logic [RW-1:0]              r_row2;

    logic                       w_accept, w_adv1, w_adv2, w_calc_busy;
    logic [SUM_W-1:0]           w_sum;
    logic [CW-1:0]              w_cur_col;
    logic [RW-1:0]              w_cur_row;
    logic [EW-1:0]              w_eff_width;
    logic [EW-1:0]              w_col_inc;
    logic                       w_full;
    logic [LW-1:0]              w_rd_data;
    logic [LW-1:0]              w_wr_data;
    logic [TW-1:0]              w_su, w_sd;
    logic [SUM_W-1:0]           w_ctr;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_weight    <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_ROW_WIDTH: r_row_width <= i_cfg_data[ROW_WIDTH_W-1:0];
                CFG_WEIGHT:    r_weight    <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake chain
    assign w_adv2   = r_v2 && !w_calc_busy;
    assign w_adv1   = r_v1 && (!r_v2 || w_adv2);
    assign o_stall  = r_v1 && !w_adv1;
    assign w_accept = i_valid && !o_stall;

    // pixel position
    assign w_sum     = SUM_W'(i_blue) + SUM_W'(i_green) + SUM_W'(i_red);
    assign w_cur_col = i_start_of_frame ? '0 : r_col;
    assign w_cur_row = i_start_of_frame ? '0 : r_row;
    assign w_col_inc = EW'(w_cur_col) + EW'(1);
    assign w_full    = (32'(w_cur_row) >= 32'(MSIZE - 1))
                    && (32'(w_cur_col) >= 32'(MSIZE - 1));

    always_comb begin
        if (r_row_width == '0) begin
            w_eff_width = EW'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            w_eff_width = EW'(MAX_WIDTH);
        end else begin
            w_eff_width = EW'(r_row_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_col_inc >= w_eff_width) begin
                r_col <= '0;
                if (32'(w_cur_row) < 32'(MAX_HEIGHT - 1)) begin
                    r_row <= w_cur_row + RW'(1);
                end else begin
                    r_row <= w_cur_row;
                end
            end else begin
                r_col <= w_col_inc[CW-1:0];
                r_row <= w_cur_row;
            end
        end
    end

    // line store read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_adv1) begin
                r_v1 <= 1'b0;
            end
            if (w_adv1) begin
                r_v2 <= r_full1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_full1 <= w_full;
            r_sum1  <= w_sum;
            r_col1  <= w_cur_col;
            r_row1  <= w_cur_row;
        end
        if (w_adv1) begin
            r_col2 <= r_col1 - CW'(HALF);
            r_row2 <= r_row1 - RW'(HALF);
        end
    end

    // drop the oldest stored row, append the current sum
    assign w_wr_data = {r_sum1, w_rd_data[LW-1:SUM_W]};

    nce_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_cur_col),
        .i_wr_en   (w_adv1),
        .i_wr_addr (r_col1),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    nce_window #(
        .MSIZE (MSIZE)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv1),
        .i_col_data (w_rd_data),
        .i_sum      (r_sum1),
        .o_su       (w_su),
        .o_sd       (w_sd),
        .o_ctr      (w_ctr)
    );

    nce_calc #(
        .TW (TW),
        .CW (CW),
        .RW (RW)
    ) u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_v2),
        .o_busy       (w_calc_busy),
        .i_su         (w_su),
        .i_sd         (w_sd),
        .i_ctr        (w_ctr),
        .i_col        (r_col2),
        .i_row        (r_row2),
        .i_weight     (r_weight),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_edge_value (o_edge_value),
        .o_center_col (o_center_col),
        .o_center_row (o_center_row)
    );

    // checks
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(MAX_WIDTH))
        else $error("column counter beyond the line store");

    a_centre_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_center_col) >= 32'(HALF)) && (32'(o_center_row) >= 32'(HALF)))
        else $error("result beat for a border pixel");

    a_sof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_start_of_frame) |=> (r_col1 == '0) && (r_row1 == '0))
        else $error("start of frame did not restart the position");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv1 && !r_full1) |=> !r_v2)
        else $error("border pixel entered the response pipeline");

endmodule

[rtl/nce_line_mem.sv]
// line store: one entry per column holding the sums of the stored rows
// one write and one registered read per cycle, same-edge write bypassed; uses nce_pkg
module nce_line_mem import nce_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int DATA_W = (DEF_MSIZE - 1) * SUM_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_byp_data;
    logic              r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;

endmodule

[rtl/nce_window.sv]
// window of column sums: upper and lower partial sums per column, window totals
// and the centre row values; uses nce_pkg
module nce_window import nce_pkg::*; #(
    parameter int MSIZE = DEF_MSIZE,
    localparam int LINES = MSIZE - 1,
    localparam int TW    = SUM_W + 2 * $clog2(MSIZE)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [LINES*SUM_W-1:0] i_col_data,
    input  logic [SUM_W-1:0]       i_sum,
    output logic [TW-1:0]          o_su,
    output logic [TW-1:0]          o_sd,
    output logic [SUM_W-1:0]       o_ctr
);

    localparam int HALF = MSIZE / 2;
    localparam int CSW  = SUM_W + $clog2(MSIZE);
    localparam int MIDN = MSIZE - HALF;

    logic [SUM_W-1:0] w_vals [MSIZE];
    logic [CSW-1:0]   w_up;
    logic [CSW-1:0]   w_dn;
    logic [TW-1:0]    w_su;
    logic [TW-1:0]    w_sd;

    logic [CSW-1:0]   r_up  [MSIZE];
    logic [CSW-1:0]   r_dn  [MSIZE];
    logic [SUM_W-1:0] r_mid [MIDN];

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            w_vals[i] = i_col_data[i*SUM_W +: SUM_W];
        end
        w_vals[LINES] = i_sum;
        w_up = '0;
        w_dn = '0;
        for (int i = 0; i < MSIZE; i++) begin
            if (i <= HALF) begin
                w_up = w_up + CSW'(w_vals[i]);
            end else begin
                w_dn = w_dn + CSW'(w_vals[i]);
            end
        end
    end

    // totals over the columns held in the window
    always_comb begin
        w_su = '0;
        w_sd = '0;
        for (int i = 0; i < MSIZE; i++) begin
            w_su = w_su + TW'(r_up[i]);
            w_sd = w_sd + TW'(r_dn[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MSIZE; i++) begin
                r_up[i] <= '0;
                r_dn[i] <= '0;
            end
            for (int i = 0; i < MIDN; i++) begin
                r_mid[i] <= '0;
            end
        end else if (i_adv) begin
            for (int i = 0; i < MSIZE - 1; i++) begin
                r_up[i] <= r_up[i+1];
                r_dn[i] <= r_dn[i+1];
            end
            r_up[MSIZE-1] <= w_up;
            r_dn[MSIZE-1] <= w_dn;
            for (int i = 0; i < MIDN - 1; i++) begin
                r_mid[i] <= r_mid[i+1];
            end
            r_mid[MIDN-1] <= w_vals[HALF];
        end
    end

    assign o_su  = w_su;
    assign o_sd  = w_sd;
    assign o_ctr = r_mid[0];

endmodule

[rtl/nce_calc.sv]
// mask response: difference of window sums, weight multiply, divide by three,
// clamp and output register; uses nce_pkg
module nce_calc import nce_pkg::*; #(
    parameter int TW = SUM_W + 2 * $clog2(DEF_MSIZE),
    parameter int CW = $clog2(DEF_MAX_WIDTH),
    parameter int RW = $clog2(DEF_MAX_HEIGHT)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_busy,
    input  logic [TW-1:0]              i_su,
    input  logic [TW-1:0]              i_sd,
    input  logic [SUM_W-1:0]           i_ctr,
    input  logic [CW-1:0]              i_col,
    input  logic [RW-1:0]              i_row,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [CH_W-1:0]            o_edge_value,
    output logic [CW-1:0]              o_center_col,
    output logic [RW-1:0]              o_center_row
);

    localparam int DW = TW + 2;
    localparam int PW = DW + WEIGHT_W;

    logic                 r_v3, r_v4, r_vo;
    logic signed [DW-1:0] r_d;
    logic signed [PW-1:0] r_prod;
    logic [CW-1:0]        r_col3, r_col4, r_col_o;
    logic [RW-1:0]        r_row3, r_row4, r_row_o;
    logic [CH_W-1:0]      r_edge;

    logic                  w_adv_in, w_adv3, w_adv4, w_adv_o;
    logic signed [DW-1:0]  w_d;
    logic [DIV3_IN_W-1:0]  w_t;
    logic [DIV3_PR_W-1:0]  w_q;
    logic [CH_W-1:0]       w_edge;

    assign w_adv_o  = r_vo && !i_stall;
    assign w_adv4   = r_v4 && (!r_vo || w_adv_o);
    assign w_adv3   = r_v3 && (!r_v4 || w_adv4);
    assign o_busy   = r_v3 && !w_adv3;
    assign w_adv_in = i_valid && !o_busy;

    assign w_d = $signed({2'b00, i_su}) - $signed({2'b00, i_sd})
               - $signed(DW'(3 * int'(i_ctr)));

    assign w_t = r_prod[DIV3_IN_W-1:0];
    assign w_q = DIV3_PR_W'(w_t) * DIV3_PR_W'(DIV3_RECIP);

    always_comb begin
        if (r_prod <= 0) begin
            w_edge = '0;
        end else if (r_prod >= $signed(PW'(DIV3_LIMIT))) begin
            w_edge = CLAMP_MAX;
        end else begin
            w_edge = w_q[DIV3_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_adv_in) begin
                r_v3 <= 1'b1;
            end else if (w_adv3) begin
                r_v3 <= 1'b0;
            end
            if (w_adv3) begin
                r_v4 <= 1'b1;
            end else if (w_adv4) begin
                r_v4 <= 1'b0;
            end
            if (w_adv4) begin
                r_vo <= 1'b1;
            end else if (w_adv_o) begin
                r_vo <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in) begin
            r_d    <= w_d;
            r_col3 <= i_col;
            r_row3 <= i_row;
        end
        if (w_adv3) begin
            r_prod <= PW'(r_d) * PW'(i_weight);
            r_col4 <= r_col3;
            r_row4 <= r_row3;
        end
        if (w_adv4) begin
            r_edge  <= w_edge;
            r_col_o <= r_col4;
            r_row_o <= r_row4;
        end
    end

    assign o_valid      = r_vo;
    assign o_edge_value = r_edge;
    assign o_center_col = r_col_o;
    assign o_center_row = r_row_o;

endmodule

[bench/north_compass_edge_filter_core_tb.sv]
// self-checking bench for north_compass_edge_filter_core: directed table, then random frames
// checked against a behavioural predictor of the line store, window and clamped response
// depends on rtl/nce_pkg.sv and the core rtl only
module north_compass_edge_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nce_pkg::*;

    localparam int COL_W = $clog2(DEF_MAX_WIDTH);
    localparam int ROW_W = $clog2(DEF_MAX_HEIGHT);

    typedef struct packed {
        logic [CH_W-1:0]  value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_edge_res;

    typedef enum logic {DIR_PIXEL, DIR_CONFIG} t_dir_kind;

    typedef struct packed {
        t_dir_kind             kind;
        logic                  sof;
        logic [CH_W-1:0]       blue;
        logic [CH_W-1:0]       green;
        logic [CH_W-1:0]       red;
        logic                  typed;
        t_edge_res             expected;
        t_cfg_reg              sel;
        logic [CFG_DATA_W-1:0] val;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CH_W-1:0]       i_blue = '0;
    logic [CH_W-1:0]       i_green = '0;
    logic [CH_W-1:0]       i_red = '0;
    logic                  i_start_of_frame = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [CH_W-1:0]       o_edge_value;
    logic [COL_W-1:0]      o_center_col;
    logic [ROW_W-1:0]      o_center_row;

    north_compass_edge_filter_core i_dut (.*);

    // predictor state
    logic [SUM_W-1:0]       sum_lines [2][DEF_MAX_WIDTH];
    logic [SUM_W-1:0]       sum_win [3][3];
    logic [COL_W-1:0]       pos_col = '0;
    logic [ROW_W-1:0]       pos_row = '0;
    logic [ROW_WIDTH_W-1:0] cfg_width = ROW_WIDTH_RST;
    logic signed [7:0]      cfg_weight = WEIGHT_RST;

    t_edge_res pending_edges [$];
    t_dir_row  directed [$];
    bit        quiet = 1'b0;
    int        mismatches = 0;
    int        pixels_sent = 0;
    int        edges_checked = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic predict_edge(input logic sof, input logic [CH_W-1:0] b, g, r,
                                output bit hit, output t_edge_res res);
        logic [SUM_W-1:0] s;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        int unsigned      eff_w;
        longint           w, tap, total, q;
        s = 10'(b) + 10'(g) + 10'(r);
        eff_w = (cfg_width == 0) ? 1 : (cfg_width > 12'd2048) ? 2048 : int'(cfg_width);
        if (sof) begin
            pos_col = '0;
            pos_row = '0;
        end
        col = pos_col;
        row = pos_row;
        for (int i = 0; i < 3; i++) begin
            sum_win[i][0] = sum_win[i][1];
            sum_win[i][1] = sum_win[i][2];
        end
        sum_win[0][2] = sum_lines[0][col];
        sum_win[1][2] = sum_lines[1][col];
        sum_win[2][2] = s;
        sum_lines[0][col] = sum_lines[1][col];
        sum_lines[1][col] = s;
        hit = (row >= 2) && (col >= 2);
        res = '0;
        if (hit) begin
            w = cfg_weight;
            total = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i == 1 && j == 1) tap = -2 * w;
                    else if (i <= 1) tap = w;
                    else tap = -w;
                    total += tap * longint'(sum_win[i][j]);
                end
            end
            if (total <= 0) q = 0;
            else q = (total / 3 > 255) ? 255 : total / 3;
            res.value = 8'(q);
            res.col = col - 11'd1;
            res.row = row - 11'd1;
        end
        if (32'(col) + 1 >= eff_w) begin
            pos_col = '0;
            if (row < 11'(DEF_MAX_HEIGHT - 1)) pos_row = row + 11'd1;
        end else begin
            pos_col = col + 11'd1;
        end
    endtask

    task automatic send_pixel(input logic sof, input logic [CH_W-1:0] b, g, r,
                              input bit typed, input t_edge_res typed_res);
        bit        hit;
        t_edge_res res;
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 19) begin
            i_valid <= 1'b0;
            i_blue <= 8'($urandom);
            i_green <= 8'($urandom);
            i_red <= 8'($urandom);
            i_start_of_frame <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_of_frame <= sof;
        i_blue <= b;
        i_green <= g;
        i_red <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_edge(sof, b, g, r, hit, res);
        if (typed) pending_edges.push_back(typed_res);
        else if (hit) pending_edges.push_back(res);
        pixels_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= sel;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            CFG_ROW_WIDTH: cfg_width = val;
            CFG_WEIGHT:    cfg_weight = val[7:0];
            default:       ;
        endcase
    endtask

    // one stretch of pixels whose channels sit in a random band, with stray extremes
    task automatic send_run(input int count, input bit open_frame, input bit broken);
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] ch [3];
        logic            sof;
        lo = 8'($urandom_range(0, 255));
        hi = 8'($urandom_range(lo, 255));
        for (int k = 0; k < count; k++) begin
            sof = (open_frame && k == 0) || (broken && $urandom_range(0, 99) < 4);
            for (int c = 0; c < 3; c++) begin
                if ($urandom_range(0, 15) == 0) ch[c] = {8{$urandom_range(0, 1) == 1}};
                else ch[c] = 8'($urandom_range(lo, hi));
            end
            send_pixel(sof, ch[0], ch[1], ch[2], 1'b0, '0);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_weight();
        int sw;
        if ($urandom_range(0, 3) == 0) sw = $urandom_range(0, 255) - 128;
        else sw = $urandom_range(0, 12) - 6;
        return {4'($urandom), 8'(sw)};
    endfunction

    function automatic t_dir_row dir_pix(input logic sof, input logic [CH_W-1:0] b, g, r);
        t_dir_row d;
        d = '0;
        d.kind = DIR_PIXEL;
        d.sof = sof;
        d.blue = b;
        d.green = g;
        d.red = r;
        d.sel = CFG_ROW_WIDTH;
        return d;
    endfunction

    function automatic t_dir_row dir_pix_exp(input logic sof, input logic [CH_W-1:0] b, g, r,
                                             input logic [CH_W-1:0] v,
                                             input logic [COL_W-1:0] c,
                                             input logic [ROW_W-1:0] rw);
        t_dir_row d;
        d = dir_pix(sof, b, g, r);
        d.typed = 1'b1;
        d.expected = '{value: v, col: c, row: rw};
        return d;
    endfunction

    function automatic t_dir_row dir_cfg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] val);
        t_dir_row d;
        d = '0;
        d.kind = DIR_CONFIG;
        d.sel = sel;
        d.val = val;
        return d;
    endfunction

    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 19);
    end

    always @(posedge i_clk) begin
        t_edge_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_edges.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat value %0d col %0d row %0d",
                                        o_edge_value, o_center_col, o_center_row));
            end else begin
                exp_res = pending_edges.pop_front();
                edges_checked++;
                if (o_edge_value !== exp_res.value)
                    flag_mismatch($sformatf("edge value %0d, wanted %0d (col %0d row %0d)",
                                            o_edge_value, exp_res.value, exp_res.col,
                                            exp_res.row));
                if (o_center_col !== exp_res.col)
                    flag_mismatch($sformatf("centre column %0d, wanted %0d",
                                            o_center_col, exp_res.col));
                if (o_center_row !== exp_res.row)
                    flag_mismatch($sformatf("centre row %0d, wanted %0d",
                                            o_center_row, exp_res.row));
            end
        end
    end

    initial begin
        int width;
        int count;
        int random_pixels;
        bit broken;
        int odd_widths [4];
        for (int i = 0; i < 2; i++)
            for (int c = 0; c < DEF_MAX_WIDTH; c++) sum_lines[i][c] = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) sum_win[i][j] = '0;
        directed = '{
            dir_cfg(CFG_ROW_WIDTH, 12'd3), dir_cfg(CFG_WEIGHT, 12'd1),
            // bright rows above a dark row: full positive response
            dir_pix(1, 255, 255, 255), dir_pix(0, 255, 255, 255), dir_pix(0, 255, 255, 255),
            dir_pix(0, 255, 255, 255), dir_pix(0, 255, 255, 255), dir_pix(0, 255, 255, 255),
            dir_pix(0, 0, 0, 0), dir_pix(0, 0, 0, 0), dir_pix_exp(0, 0, 0, 0, 255, 1, 1),
            // most negative weight, dark rows above a bright row
            dir_cfg(CFG_WEIGHT, 12'h080),
            dir_pix(1, 0, 0, 0), dir_pix(0, 0, 0, 0), dir_pix(0, 0, 0, 0),
            dir_pix(0, 0, 0, 0), dir_pix(0, 0, 0, 0), dir_pix(0, 0, 0, 0),
            dir_pix(0, 255, 255, 255), dir_pix(0, 255, 255, 255),
            dir_pix_exp(0, 255, 255, 255, 255, 1, 1),
            // largest weight with a negative total clamps to zero
            dir_cfg(CFG_WEIGHT, 12'd127),
            dir_pix(0, 255, 255, 255), dir_pix(0, 255, 0, 255),
            dir_pix_exp(0, 255, 255, 255, 0, 1, 2),
            dir_cfg(CFG_WEIGHT, 12'd0),
            dir_pix(0, 0, 128, 255), dir_pix(0, 1, 2, 3), dir_pix_exp(0, 1, 2, 3, 0, 1, 3)
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == DIR_CONFIG) begin
                drain_results();
                write_reg(directed[k].sel, directed[k].val);
            end else begin
                send_pixel(directed[k].sof, directed[k].blue, directed[k].green,
                           directed[k].red, directed[k].typed, directed[k].expected);
            end
        end

        // widths that never fill the window, and one beyond the line store
        odd_widths = '{0, 1, 2, 4095};
        foreach (odd_widths[k]) begin
            drain_results();
            write_reg(CFG_ROW_WIDTH, 12'(odd_widths[k]));
            write_reg(CFG_WEIGHT, pick_weight());
            send_run(40, 1'b1, 1'b0);
        end

        // row shortened part way through by a lower width
        drain_results();
        write_reg(CFG_ROW_WIDTH, 12'd10);
        write_reg(CFG_WEIGHT, 12'd1);
        send_run(35, 1'b1, 1'b0);
        drain_results();
        write_reg(CFG_ROW_WIDTH, 12'd4);
        send_run(12, 1'b0, 1'b0);

        // long stretch with no idling on either side
        drain_results();
        write_reg(CFG_ROW_WIDTH, 12'd3);
        write_reg(CFG_WEIGHT, 12'd2);
        quiet = 1'b1;
        send_run(150, 1'b1, 1'b0);
        drain_results();
        quiet = 1'b0;

        random_pixels = 0;
        while (random_pixels < 720) begin
            drain_results();
            if ($urandom_range(0, 3) != 0) width = $urandom_range(3, 12);
            else width = $urandom_range(13, 64);
            write_reg(CFG_ROW_WIDTH, 12'(width));
            write_reg(CFG_WEIGHT, pick_weight());
            repeat ($urandom_range(1, 3)) begin
                if (random_pixels < 720) begin
                    broken = ($urandom_range(0, 4) == 0);
                    count = width * $urandom_range(3, 6);
                    if (broken) count = $urandom_range(1, count);
                    if (count > 720 - random_pixels) count = 720 - random_pixels;
                    send_run(count, 1'b1, broken);
                    random_pixels += count;
                end
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("run: %0d pixels sent, %0d filter responses compared", pixels_sent,
                 edges_checked);
        $display("run: widths 0 to 4095, weights -128 to 127, short rows, a gapless stretch");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
